>>> sv/wcec_pkg.sv
// ----------------------------------------------------------------------------
// wcec_pkg
// Shared types and constants for the walking compare epoch clock.
// ----------------------------------------------------------------------------
`default_nettype none

package wcec_pkg;

   // action codes
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam int TPM_W     = 31;
   localparam int TICK_W    = 32;
   localparam int UPTIME_W  = 64;
   localparam int SEC_W     = 32;
   localparam int MILLIS_W  = 10;

   localparam logic [TPM_W-1:0] TPM_RESET = 31'd48000;

   // divide by 1000, one 16-bit digit per step, high digit first
   localparam int MS_PER_SEC  = 1000;
   localparam int DIGIT_W     = 16;
   localparam int DIGITS      = UPTIME_W / DIGIT_W;
   localparam int X_W         = MILLIS_W + DIGIT_W;
   localparam int RECIP_W     = 27;
   localparam int PROD_W      = X_W + RECIP_W;
   localparam int RECIP_SHIFT = 36;
   // ceil(2^36 / 1000); exact for any dividend below 1000 * 2^16
   localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]          action;
      logic [SEC_W-1:0]    set_seconds;
      logic [MILLIS_W-1:0] set_millis;
   } req_type;

   typedef struct packed {
      logic [UPTIME_W-1:0] uptime_ms;
      logic [SEC_W-1:0]    epoch_seconds;
      logic [MILLIS_W-1:0] epoch_millis;
      logic                time_valid;
   } rsp_type;

   // snapshot of clock state taken by a read
   typedef struct packed {
      logic [UPTIME_W-1:0] uptime;
      logic [SEC_W-1:0]    anchor_seconds;
      logic [TICK_W-1:0]   anchor_uptime;
      logic                synced;
   } snap_type;

endpackage

`default_nettype wire

>>> sv/wcec_front.sv
// ----------------------------------------------------------------------------
// wcec_front
// Accepts words, runs ticks and set actions on the clock state, and pushes
// a state snapshot for every read into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wcec_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire wcec_pkg::req_type             req_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [wcec_pkg::TPM_W-1:0]    csr_data,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output wcec_pkg::snap_type                 push_data
);

   logic [wcec_pkg::TPM_W-1:0]    tpm_ff;
   logic [wcec_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [wcec_pkg::TICK_W-1:0]   cmp_ff, cmp_in;
   logic [wcec_pkg::UPTIME_W-1:0] ms_ff, ms_in;
   logic [wcec_pkg::SEC_W-1:0]    anc_sec_ff, anc_sec_in;
   logic [wcec_pkg::TICK_W-1:0]   anc_up_ff, anc_up_in;
   logic                          synced_ff, synced_in;

   logic                          is_tick, is_set, is_read, accept;
   logic [wcec_pkg::TICK_W-1:0]   tick_next, diff, step;

   always_comb begin
      is_tick = 1'b0;
      is_set  = 1'b0;
      is_read = 1'b0;
      unique case (req_data.action)
         wcec_pkg::ACT_TICK: is_tick = 1'b1;
         wcec_pkg::ACT_SET:  is_set  = 1'b1;
         wcec_pkg::ACT_READ: is_read = 1'b1;
         default: ;
      endcase
   end

   // only reads need queue room
   assign req_ready  = push_ready || !is_read;
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign push_valid = req_valid && is_read;
   assign push_data  = '{uptime:         ms_ff,
                         anchor_seconds: anc_sec_ff,
                         anchor_uptime:  anc_up_ff,
                         synced:         synced_ff};

   assign step      = (tpm_ff == '0) ? wcec_pkg::TICK_W'(1) : {1'b0, tpm_ff};
   assign tick_next = tick_ff + wcec_pkg::TICK_W'(1);
   assign diff      = tick_next - cmp_ff;

   always_comb begin
      tick_in    = tick_ff;
      cmp_in     = cmp_ff;
      ms_in      = ms_ff;
      anc_sec_in = anc_sec_ff;
      anc_up_in  = anc_up_ff;
      synced_in  = synced_ff;
      if (accept && is_tick) begin
         tick_in = tick_next;
         // signed difference not negative: compare point reached
         if (!diff[wcec_pkg::TICK_W-1]) begin
            cmp_in = cmp_ff + step;
            ms_in  = ms_ff + wcec_pkg::UPTIME_W'(1);
         end
      end
      if (accept && is_set) begin
         anc_sec_in = req_data.set_seconds;
         anc_up_in  = ms_ff[wcec_pkg::TICK_W-1:0]
                      - wcec_pkg::TICK_W'(req_data.set_millis);
         synced_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff     <= wcec_pkg::TPM_RESET;
         tick_ff    <= '0;
         cmp_ff     <= wcec_pkg::TICK_W'(wcec_pkg::TPM_RESET);
         ms_ff      <= '0;
         anc_sec_ff <= '0;
         anc_up_ff  <= '0;
         synced_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            tpm_ff <= csr_data;
         end
         tick_ff    <= tick_in;
         cmp_ff     <= cmp_in;
         ms_ff      <= ms_in;
         anc_sec_ff <= anc_sec_in;
         anc_up_ff  <= anc_up_in;
         synced_ff  <= synced_in;
      end
   end

   a_ms_step: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick) |=>
         (ms_ff == $past(ms_ff)) || (ms_ff == $past(ms_ff) + wcec_pkg::UPTIME_W'(1)))
      else $error("ms count moved by more than one on a tick");

endmodule

`default_nettype wire

>>> sv/wcec_queue.sv
// ----------------------------------------------------------------------------
// wcec_queue
// Short FIFO of read snapshots between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module wcec_queue #(
   parameter int DEPTH = wcec_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire wcec_pkg::snap_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output wcec_pkg::snap_type      pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   wcec_pkg::snap_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_en, pop_en;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_en    = push_valid && push_ready;
   assign pop_en     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

>>> sv/wcec_back.sv
// ----------------------------------------------------------------------------
// wcec_back
// Read pipeline: elapsed ms, then divide by 1000 one 16-bit digit per
// two stages (reciprocal multiply, then remainder), then output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wcec_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire wcec_pkg::snap_type pop_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output wcec_pkg::rsp_type       rsp_data
);

   localparam int DIGITS   = wcec_pkg::DIGITS;
   localparam int DIGIT_W  = wcec_pkg::DIGIT_W;
   localparam int UPTIME_W = wcec_pkg::UPTIME_W;
   localparam int X_W      = wcec_pkg::X_W;
   localparam int PROD_W   = wcec_pkg::PROD_W;
   localparam int MILLIS_W = wcec_pkg::MILLIS_W;

   typedef struct packed {
      logic [UPTIME_W-1:0]          uptime;
      logic [wcec_pkg::SEC_W-1:0]   anchor_seconds;
      logic                         synced;
   } meta_type;

   // b stages: digit results (index 0 is the entry stage)
   logic                b_valid_ff [DIGITS+1];
   meta_type            b_meta_ff  [DIGITS+1];
   logic [UPTIME_W-1:0] b_base_ff  [DIGITS+1];
   logic [UPTIME_W-1:0] b_quo_ff   [DIGITS+1];
   logic [MILLIS_W-1:0] b_rem_ff   [DIGITS+1];
   // a stages: reciprocal products
   logic                a_valid_ff [DIGITS];
   meta_type            a_meta_ff  [DIGITS];
   logic [UPTIME_W-1:0] a_base_ff  [DIGITS];
   logic [UPTIME_W-1:0] a_quo_ff   [DIGITS];
   logic [X_W-1:0]      a_x_ff     [DIGITS];
   logic [PROD_W-1:0]   a_prod_ff  [DIGITS];

   logic                rsp_valid_ff;
   wcec_pkg::rsp_type   rsp_data_ff;
   logic                adv;
   logic [UPTIME_W-1:0] base_in;
   logic [wcec_pkg::SEC_W-1:0] esec_in;

   // whole pipeline holds while the output word waits
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign base_in = pop_data.synced
                    ? pop_data.uptime - UPTIME_W'(pop_data.anchor_uptime)
                    : pop_data.uptime;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         b_valid_ff[0] <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_meta_ff[0] <= '{uptime:         pop_data.uptime,
                           anchor_seconds: pop_data.anchor_seconds,
                           synced:         pop_data.synced};
         b_base_ff[0] <= base_in;
         b_quo_ff[0]  <= '0;
         b_rem_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < DIGITS; k++) begin : g_digit
      logic [X_W-1:0]     x_in;
      logic [PROD_W-1:0]  prod_in;
      logic [DIGIT_W-1:0] q_in;
      logic [X_W-1:0]     r_in;

      assign x_in    = {b_rem_ff[k], b_base_ff[k][(DIGITS-1-k)*DIGIT_W +: DIGIT_W]};
      assign prod_in = PROD_W'(x_in) * PROD_W'(wcec_pkg::RECIP);
      assign q_in    = a_prod_ff[k][wcec_pkg::RECIP_SHIFT +: DIGIT_W];
      assign r_in    = a_x_ff[k] - X_W'(q_in) * X_W'(wcec_pkg::MS_PER_SEC);

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k]   <= 1'b0;
            b_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            a_valid_ff[k]   <= b_valid_ff[k];
            b_valid_ff[k+1] <= a_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            a_meta_ff[k]   <= b_meta_ff[k];
            a_base_ff[k]   <= b_base_ff[k];
            a_quo_ff[k]    <= b_quo_ff[k];
            a_x_ff[k]      <= x_in;
            a_prod_ff[k]   <= prod_in;
            b_meta_ff[k+1] <= a_meta_ff[k];
            b_base_ff[k+1] <= a_base_ff[k];
            b_quo_ff[k+1]  <= {a_quo_ff[k][UPTIME_W-DIGIT_W-1:0], q_in};
            b_rem_ff[k+1]  <= r_in[MILLIS_W-1:0];
         end
      end
   end

   assign esec_in = b_meta_ff[DIGITS].synced
                    ? b_meta_ff[DIGITS].anchor_seconds
                      + b_quo_ff[DIGITS][wcec_pkg::SEC_W-1:0]
                    : b_quo_ff[DIGITS][wcec_pkg::SEC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid_ff[DIGITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= '{uptime_ms:     b_meta_ff[DIGITS].uptime,
                          epoch_seconds: esec_in,
                          epoch_millis:  b_rem_ff[DIGITS],
                          time_valid:    b_meta_ff[DIGITS].synced};
      end
   end

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff[DIGITS] |-> (b_rem_ff[DIGITS] < MILLIS_W'(wcec_pkg::MS_PER_SEC)))
      else $error("remainder out of range");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop_ready)
      else $error("queue popped while output stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (b_valid_ff[DIGITS] == $past(b_valid_ff[DIGITS])))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

>>> sv/walking_compare_epoch_clock_top.sv
// ----------------------------------------------------------------------------
// walking_compare_epoch_clock_top
// Millisecond clock with a walking tick compare and an epoch anchor.
//
// req_*: one word per action: tick, set epoch, or read. Ticks and sets act
//   on the clock state in the cycle taken, with no result; a word is taken
//   every cycle bar full-queue reads. Reads always see every earlier word.
// rsp_*: one word per read: uptime ms, epoch seconds/millis, valid flag.
// csr_*: step size (clock ticks per ms) write, always ready; write only
//   while idle.
// A read's result passes the snapshot queue and the 64-bit divide by 1000:
//   an entry register, four 16-bit digit steps of two stages each, and an
//   output register. Reads flow one per cycle while rsp_ready stays high.
// When the receiver stalls the read pipeline holds; reads pile up in the
//   snapshot queue, and once it is full req_ready drops for reads only.
// Reset (synchronous) clears the counters and the sync flag, sets the step
//   size and the compare point to 48000, and empties all stages.
// ----------------------------------------------------------------------------
`default_nettype none

module walking_compare_epoch_clock_top #(
   parameter int QUEUE_DEPTH = wcec_pkg::QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire wcec_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output wcec_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [wcec_pkg::TPM_W-1:0] csr_data
);

   logic               push_valid, push_ready;
   wcec_pkg::snap_type push_data;
   logic               pop_valid, pop_ready;
   wcec_pkg::snap_type pop_data;

   wcec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   wcec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wcec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the walking compare epoch clock against an in-bench clock model.
// Ticks, epoch sets and reads are queued per phase and driven with random
// gaps; each read's uptime, epoch seconds/millis and valid flag are compared
// with the model. Phases cover the reset step, a zero step, small steps and
// the largest step, plus a long receiver hold-off that backs up the reads.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 2000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE      = 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   wcec_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   wcec_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [wcec_pkg::TPM_W-1:0] csr_data = '0;

   walking_compare_epoch_clock_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // clock model state
   logic [wcec_pkg::TPM_W-1:0]    step_reg;
   logic [wcec_pkg::TICK_W-1:0]   tick_count;
   logic [wcec_pkg::TICK_W-1:0]   compare_at;
   logic [wcec_pkg::UPTIME_W-1:0] uptime;
   logic [wcec_pkg::SEC_W-1:0]    anchor_sec;
   logic [wcec_pkg::TICK_W-1:0]   anchor_ms;
   logic                          synced;

   wcec_pkg::req_type word_backlog[$];
   wcec_pkg::rsp_type awaited_reads[$];

   int  errors = 0;
   int  reads_checked = 0;
   int  ticks_taken = 0;
   int  sets_taken = 0;
   int  stall_cycles = 0;
   int  idle_pct = 8;
   int  holds_asked = 0;
   int  holds_done = 0;
   int  hold_left = 0;
   logic req_taken = 1'b0;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   function automatic void clock_reset();
      step_reg   = wcec_pkg::TPM_RESET;
      tick_count = '0;
      compare_at = {1'b0, wcec_pkg::TPM_RESET};
      uptime     = '0;
      anchor_sec = '0;
      anchor_ms  = '0;
      synced     = 1'b0;
   endfunction

   function automatic void clock_apply(input wcec_pkg::req_type w);
      logic [wcec_pkg::TICK_W-1:0]   gap;
      logic [wcec_pkg::UPTIME_W-1:0] elapsed;
      wcec_pkg::rsp_type             r;
      case (w.action)
         wcec_pkg::ACT_TICK: begin
            tick_count = tick_count + wcec_pkg::TICK_W'(1);
            gap = tick_count - compare_at;
            // compare point reached when the signed difference is not negative
            if (!gap[wcec_pkg::TICK_W-1]) begin
               compare_at = compare_at + ((step_reg == '0) ? 32'd1 : {1'b0, step_reg});
               uptime = uptime + wcec_pkg::UPTIME_W'(1);
            end
            ticks_taken++;
         end
         wcec_pkg::ACT_SET: begin
            anchor_sec = w.set_seconds;
            anchor_ms  = wcec_pkg::TICK_W'(uptime - wcec_pkg::UPTIME_W'(w.set_millis));
            synced     = 1'b1;
            sets_taken++;
         end
         wcec_pkg::ACT_READ: begin
            elapsed = synced ? uptime - {32'd0, anchor_ms} : uptime;
            r.uptime_ms     = uptime;
            r.epoch_seconds = (synced ? anchor_sec : '0)
                              + wcec_pkg::SEC_W'(elapsed / wcec_pkg::MS_PER_SEC);
            r.epoch_millis  = wcec_pkg::MILLIS_W'(elapsed % wcec_pkg::MS_PER_SEC);
            r.time_valid    = synced;
            awaited_reads.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   // monitor: result check, model update, stall count
   always @(posedge clock) begin : monitor
      wcec_pkg::rsp_type want;
      req_taken <= req_valid && req_ready;
      if (reset) begin
         clock_reset();
         stall_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_reads.size() == 0) begin
               flag_mismatch("result word with no read outstanding");
            end else begin
               want = awaited_reads.pop_front();
               if (rsp_data.uptime_ms !== want.uptime_ms)
                  flag_mismatch($sformatf("read %0d uptime_ms got %0d want %0d",
                     reads_checked, rsp_data.uptime_ms, want.uptime_ms));
               if (rsp_data.epoch_seconds !== want.epoch_seconds)
                  flag_mismatch($sformatf("read %0d epoch_seconds got %0d want %0d",
                     reads_checked, rsp_data.epoch_seconds, want.epoch_seconds));
               if (rsp_data.epoch_millis !== want.epoch_millis)
                  flag_mismatch($sformatf("read %0d epoch_millis got %0d want %0d",
                     reads_checked, rsp_data.epoch_millis, want.epoch_millis));
               if (rsp_data.time_valid !== want.time_valid)
                  flag_mismatch($sformatf("read %0d time_valid got %0b want %0b",
                     reads_checked, rsp_data.time_valid, want.time_valid));
               reads_checked++;
            end
         end
         if (csr_valid && csr_ready)
            step_reg = csr_data;
         if (req_valid && req_ready)
            clock_apply(req_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // driver: next word goes out once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (word_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data  <= word_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus requested long hold-offs
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void queue_word(input logic [1:0] act,
                                      input logic [wcec_pkg::SEC_W-1:0] secs,
                                      input logic [wcec_pkg::MILLIS_W-1:0] ms);
      wcec_pkg::req_type w;
      w.action      = act;
      w.set_seconds = secs;
      w.set_millis  = ms;
      word_backlog.push_back(w);
   endfunction

   function automatic void queue_random(input logic [1:0] act);
      queue_word(act, $urandom(), wcec_pkg::MILLIS_W'($urandom_range(0, 1023)));
   endfunction

   function automatic void tick_run(input int n);
      repeat (n) queue_random(wcec_pkg::ACT_TICK);
   endfunction

   // runs of ticks closed by a read, with sets and unused codes mixed in
   function automatic void random_phase(input int count);
      int done;
      int pick;
      int n;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            queue_random(wcec_pkg::ACT_SET);
         end else if (pick < 11) begin
            queue_random(ACT_UNUSED);
         end else begin
            n = $urandom_range(1, 12);
            tick_run(n);
            queue_random(wcec_pkg::ACT_READ);
            done += n;
         end
         done++;
      end
   endfunction

   task automatic drain();
      while (word_backlog.size() != 0 || req_valid || awaited_reads.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_step(input logic [wcec_pkg::TPM_W-1:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset step: boot-relative reads, wrapped anchor, unused code
      queue_random(wcec_pkg::ACT_READ);
      queue_word(ACT_UNUSED, '1, '1);
      queue_word(wcec_pkg::ACT_SET, '1, 10'd1023);
      queue_random(wcec_pkg::ACT_READ);
      queue_word(wcec_pkg::ACT_SET, '0, '0);
      queue_random(wcec_pkg::ACT_READ);
      queue_random(wcec_pkg::ACT_TICK);
      queue_random(wcec_pkg::ACT_READ);
      queue_word(wcec_pkg::ACT_SET, 32'd12345, 10'd999);
      queue_random(wcec_pkg::ACT_READ);
      queue_random(wcec_pkg::ACT_TICK);
      queue_random(wcec_pkg::ACT_READ);
      drain();
      random_phase(40);

      // zero step acts as one
      write_step('0);
      random_phase(70);

      write_step(31'd1);
      random_phase(60);

      write_step(31'd3);
      random_phase(60);

      // receiver holds off while reads keep coming
      write_step(31'd2);
      holds_asked++;
      repeat (40) begin
         if ($urandom_range(3) == 0)
            queue_random(wcec_pkg::ACT_TICK);
         else
            queue_random(wcec_pkg::ACT_READ);
      end
      drain();
      idle_pct = 0;
      random_phase(60);
      drain();
      idle_pct = 8;

      // largest step
      write_step('1);
      random_phase(60);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (awaited_reads.size() != 0)
         flag_mismatch($sformatf("%0d reads never answered", awaited_reads.size()));
      $display("Run covered %0d ticks, %0d epoch sets and %0d checked reads",
         ticks_taken, sets_taken, reads_checked);
      $display("Six step settings exercised, with one long receiver hold-off");
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
